FILE: sv/hplf_pkg.sv
// shared constants and helper functions for the hata path loss unit
package hplf_pkg;

  localparam int unsigned CW = 24;

  localparam logic [31:0] LOG10_2_Q32 = 32'd1292913987;

  localparam logic signed [CW-1:0] C_46_3 = 24'sd3034317;
  localparam logic signed [CW-1:0] C_33_9 = 24'sd2221670;
  localparam logic signed [CW-1:0] C_13_82 = 24'sd905708;
  localparam logic signed [CW-1:0] C_44_9 = 24'sd2942566;
  localparam logic signed [CW-1:0] C_6_55 = 24'sd429261;
  localparam logic signed [CW-1:0] C_8_29 = 24'sd543293;
  localparam logic signed [CW-1:0] C_1_1 = 24'sd72090;
  localparam logic signed [CW-1:0] C_3_2 = 24'sd209715;
  localparam logic signed [CW-1:0] C_4_97 = 24'sd325714;
  localparam logic signed [CW-1:0] C_0_8 = 24'sd52429;
  localparam logic signed [CW-1:0] C_1_56 = 24'sd102236;
  localparam logic signed [CW-1:0] C_0_7 = 24'sd45875;
  localparam logic signed [CW-1:0] C_3 = 24'sd196608;

  localparam logic [20:0] K_MID = 21'd154;
  localparam logic [20:0] K_HIGH = 21'd1175;

  localparam logic signed [16:0] OUT_MIN = -17'sd16384;
  localparam logic signed [16:0] OUT_MAX = 17'sd65535;

  // reciprocal of ten in q34, rounded up
  localparam logic [30:0] RECIP10 = 31'd1717986919;

  // signed shift right with rounding half away from zero
  function automatic logic signed [63:0] rsh(logic signed [63:0] x, int s);
    logic signed [63:0] half;
    logic signed [63:0] m;
    half = 64'sd0;
    m = 64'sd0;
    if (s <= 0) begin
      return x;
    end
    half = 64'sd1 <<< (s - 1);
    if (x >= 64'sd0) begin
      return (x + half) >>> s;
    end
    m = -x;
    return -((m + half) >>> s);
  endfunction

  // log2 of a q30 mantissa by repeated squaring, rounded to fb bits
  function automatic logic [63:0] log2_pt(logic [63:0] x0, int unsigned fb);
    logic [63:0] x;
    logic [63:0] r;
    x = x0;
    r = 64'd0;
    for (int unsigned k = 0; k < fb + 1; k++) begin
      x = (x * x) >> 30;
      r = r << 1;
      if (x >= 64'h8000_0000) begin
        x = x >> 1;
        r[0] = 1'b1;
      end
    end
    return (r + 64'd1) >> 1;
  endfunction

endpackage

FILE: sv/hata_path_loss_fixed_unit.sv
// Hata path loss unit (COST231 form) in fixed point. One link description enters per
// cycle unless the output stalls; its loss in 1/256 dB leaves after an input register,
// three stages of logarithm (leading one, table interpolation, scaling by lg 2), four
// stages of products and sums, and the output register with rounding and clamping.
// A stall on the output freezes the whole pipeline; stall_o is high only then.
module hata_path_loss_fixed_unit import hplf_pkg::*; #(
  parameter int unsigned LOG_TABLE_ENTRIES = 256,
  parameter int unsigned LOG_FRAC_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  output logic               stall_o,
  input  logic [11:0]        frequency_mhz_i,
  input  logic [16:0]        distance_m_i,
  input  logic [13:0]        base_height_dm_i,
  input  logic [9:0]         mobile_height_dm_i,
  input  logic               urban_i,
  output logic               valid_o,
  input  logic               stall_i,
  output logic signed [16:0] path_loss_o,
  output logic               saturated_o
);

  localparam int unsigned F = LOG_FRAC_BITS;
  localparam int unsigned OW = F + 4;
  localparam int unsigned LW = F + 5;
  localparam int unsigned PW = F + 9;
  localparam int unsigned SW = F + 12;
  localparam int unsigned YW = F + 7;

  localparam logic signed [LW-1:0] ONE_Q = LW'(64'sd1 <<< F);
  localparam logic signed [SW-1:0] CQ_46_3 = SW'(rsh(64'(C_46_3) <<< F, 16));
  localparam logic signed [SW-1:0] CQ_44_9 = SW'(rsh(64'(C_44_9) <<< F, 16));
  localparam logic signed [SW-1:0] CQ_1_1 = SW'(rsh(64'(C_1_1) <<< F, 16));
  localparam logic signed [SW-1:0] CQ_4_97 = SW'(rsh(64'(C_4_97) <<< F, 16));
  localparam logic signed [SW-1:0] CQ_0_8 = SW'(rsh(64'(C_0_8) <<< F, 16));
  localparam logic signed [SW-1:0] CQ_0_7 = SW'(rsh(64'(C_0_7) <<< F, 16));
  localparam logic signed [SW-1:0] CQ_3 = SW'(rsh(64'(C_3) <<< F, 16));

  typedef enum logic [1:0] {BR_LOW, BR_MID, BR_HIGH} br_e;

  logic       en;
  logic [8:0] v_q;

  assign en = !(v_q[8] && stall_i);
  assign stall_o = !en;
  assign valid_o = v_q[8];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[7:0], valid_i};
    end
  end

  // input register
  logic [9:0]  hm_in;
  br_e         br_d;
  logic [11:0] f0_q;
  logic [16:0] d0_q;
  logic [13:0] hb0_q;
  logic [20:0] mk0_q;
  logic [9:0]  hm0_q;
  br_e         br0_q;
  logic        urb0_q;

  always_comb begin
    hm_in = (mobile_height_dm_i == '0) ? 10'd1 : mobile_height_dm_i;
    if (frequency_mhz_i > 12'd150 && frequency_mhz_i <= 12'd200) begin
      br_d = BR_MID;
    end else if (frequency_mhz_i > 12'd200) begin
      br_d = BR_HIGH;
    end else begin
      br_d = BR_LOW;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      f0_q <= frequency_mhz_i;
      d0_q <= distance_m_i;
      hb0_q <= base_height_dm_i;
      mk0_q <= 21'(hm_in) * ((br_d == BR_MID) ? K_MID : K_HIGH);
      hm0_q <= hm_in;
      br0_q <= br_d;
      urb0_q <= urban_i;
    end
  end

  // logarithms, stages one to three
  logic [OW-1:0] lgf;
  logic [OW-1:0] lgd;
  logic [OW-1:0] lghb;
  logic [OW-1:0] lgt;

  hplf_log10 #(.VW(12), .ENT(LOG_TABLE_ENTRIES), .FB(F)) u_lg_f (
    .clk_i(clk_i), .en_i(en), .v_i(f0_q), .lg_o(lgf)
  );
  hplf_log10 #(.VW(17), .ENT(LOG_TABLE_ENTRIES), .FB(F)) u_lg_d (
    .clk_i(clk_i), .en_i(en), .v_i(d0_q), .lg_o(lgd)
  );
  hplf_log10 #(.VW(14), .ENT(LOG_TABLE_ENTRIES), .FB(F)) u_lg_hb (
    .clk_i(clk_i), .en_i(en), .v_i(hb0_q), .lg_o(lghb)
  );
  hplf_log10 #(.VW(21), .ENT(LOG_TABLE_ENTRIES), .FB(F)) u_lg_t (
    .clk_i(clk_i), .en_i(en), .v_i(mk0_q), .lg_o(lgt)
  );

  logic [17:0] qh_prod;
  br_e         br1_q, br2_q, br3_q;
  logic [9:0]  hm1_q;
  logic [6:0]  qh1_q, qh2_q, qh3_q;
  logic [3:0]  rh2_q, rh3_q;
  logic        urb1_q, urb2_q, urb3_q;

  // mobile height split into tens and units
  assign qh_prod = 18'(hm0_q) * 18'd205;

  always_ff @(posedge clk_i) begin
    if (en) begin
      br1_q <= br0_q;
      hm1_q <= hm0_q;
      qh1_q <= qh_prod[17:11];
      urb1_q <= urb0_q;
      br2_q <= br1_q;
      qh2_q <= qh1_q;
      rh2_q <= 4'(hm1_q - 10'(qh1_q) * 10'd10);
      urb2_q <= urb1_q;
      br3_q <= br2_q;
      qh3_q <= qh2_q;
      rh3_q <= rh2_q;
      urb3_q <= urb2_q;
    end
  end

  // stage four: scale logs and form products
  logic signed [LW-1:0]    lf, ld, lhb, lt;
  logic signed [LW+CW-1:0] m339, m1382, m655, m11, m156;
  logic signed [2*LW-1:0]  mtt;
  logic signed [PW-1:0]    p339_4, p1382_4, p655_4, p11_4, p156_4, sq4;
  logic signed [LW-1:0]    ld4;
  br_e                     br4;
  logic [6:0]              qh4;
  logic [3:0]              rh4;
  logic                    urb4;

  always_comb begin
    lf = $signed({1'b0, lgf});
    ld = $signed({1'b0, lgd}) - LW'(3 * ONE_Q);
    lhb = $signed({1'b0, lghb}) - ONE_Q;
    lt = $signed({1'b0, lgt}) - LW'(3 * ONE_Q);
    m339 = C_33_9 * lf;
    m1382 = C_13_82 * lhb;
    m655 = C_6_55 * lhb;
    m11 = C_1_1 * lf;
    m156 = C_1_56 * lf;
    mtt = lt * lt;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p339_4 <= PW'(rsh(64'(m339), 16));
      p1382_4 <= PW'(rsh(64'(m1382), 16));
      p655_4 <= PW'(rsh(64'(m655), 16));
      p11_4 <= PW'(rsh(64'(m11), 16));
      p156_4 <= PW'(rsh(64'(m156), 16));
      sq4 <= PW'(rsh(64'(mtt), F));
      ld4 <= ld;
      br4 <= br3_q;
      qh4 <= qh3_q;
      rh4 <= rh3_q;
      urb4 <= urb3_q;
    end
  end

  // stage five: mobile correction terms
  logic signed [CW-1:0]    ka;
  logic signed [SW-1:0]    kb;
  logic signed [CW+PW-1:0] mam;
  logic signed [PW-1:0]    t5;
  logic [PW-1:0]           at;
  logic signed [PW-1:0]    g5, am5, p339_5, p1382_5, p156_5;
  logic [PW-1:0]           pa5;
  logic [YW-1:0]           y5;
  logic                    tneg5;
  logic signed [LW-1:0]    ld5;
  br_e                     br5;
  logic                    urb5;

  always_comb begin
    ka = (br4 == BR_MID) ? C_8_29 : C_3_2;
    kb = (br4 == BR_MID) ? CQ_1_1 : CQ_4_97;
    mam = ka * sq4;
    t5 = p11_4 - PW'(CQ_0_7);
    at = (t5 < 0) ? PW'(-t5) : PW'(t5);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      g5 <= PW'(CQ_44_9) - p655_4;
      am5 <= PW'(rsh(64'(mam), 16)) - PW'(kb);
      pa5 <= PW'(at * PW'(qh4));
      y5 <= YW'(at) * YW'(rh4) + YW'(5);
      tneg5 <= t5 < 0;
      p339_5 <= p339_4;
      p1382_5 <= p1382_4;
      p156_5 <= p156_4;
      ld5 <= ld4;
      br5 <= br4;
      urb5 <= urb4;
    end
  end

  // stage six: distance term and division by ten
  logic signed [PW+LW-1:0] mgl;
  logic [YW+30:0]          my;
  logic signed [PW-1:0]    gld6, am6, p339_6, p1382_6, p156_6;
  logic [PW-1:0]           pa6;
  logic [YW-1:0]           yd6;
  logic                    tneg6;
  br_e                     br6;
  logic                    urb6;

  assign mgl = g5 * ld5;
  assign my = (YW+31)'(y5) * (YW+31)'(RECIP10);

  always_ff @(posedge clk_i) begin
    if (en) begin
      gld6 <= PW'(rsh(64'(mgl), F));
      yd6 <= YW'(my >> 34);
      am6 <= am5;
      pa6 <= pa5;
      tneg6 <= tneg5;
      p339_6 <= p339_5;
      p1382_6 <= p1382_5;
      p156_6 <= p156_5;
      br6 <= br5;
      urb6 <= urb5;
    end
  end

  // stage seven: sum of terms
  logic signed [SW-1:0] mag, rd, a_low, a7, loss_d, loss7_q;

  always_comb begin
    mag = $signed(SW'(pa6) + SW'(yd6));
    rd = tneg6 ? -mag : mag;
    a_low = CQ_0_8 + rd - SW'(p156_6);
    a7 = (br6 == BR_LOW) ? a_low : SW'(am6);
    loss_d = CQ_46_3 + SW'(p339_6) - SW'(p1382_6) - a7 + SW'(gld6)
           + (urb6 ? CQ_3 : '0);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      loss7_q <= loss_d;
    end
  end

  // stage eight: round to 1/256 db and clamp
  logic signed [SW-1:0] r8;
  logic signed [16:0]   pl_d;
  logic                 sat_d;
  logic signed [16:0]   path_loss_q;
  logic                 sat_q;

  always_comb begin
    r8 = SW'(rsh(64'(loss7_q), F - 8));
    if (r8 > SW'(OUT_MAX)) begin
      pl_d = OUT_MAX;
      sat_d = 1'b1;
    end else if (r8 < SW'(OUT_MIN)) begin
      pl_d = OUT_MIN;
      sat_d = 1'b1;
    end else begin
      pl_d = 17'(r8);
      sat_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      path_loss_q <= pl_d;
      sat_q <= sat_d;
    end
  end

  assign path_loss_o = path_loss_q;
  assign saturated_o = sat_q;

endmodule

FILE: sv/hplf_log10.sv
// three stage fixed point base-10 logarithm of an unsigned integer
module hplf_log10 import hplf_pkg::*; #(
  parameter int unsigned VW = 17,
  parameter int unsigned ENT = 256,
  parameter int unsigned FB = 16
) (
  input  logic          clk_i,
  input  logic          en_i,
  input  logic [VW-1:0] v_i,
  output logic [FB+3:0] lg_o
);

  localparam int unsigned IB = $clog2(ENT);
  localparam int unsigned TB = $clog2(ENT + 1);
  localparam int unsigned EW = $clog2(ENT + 1);
  localparam int unsigned PB = $clog2(VW);
  localparam int unsigned L2W = FB + PB + 1;

  logic [FB:0] tab [ENT+1];

  for (genvar gi = 0; gi <= ENT; gi++) begin : g_tab
    localparam longint unsigned X0 =
      ((64'(ENT) + 64'(gi)) << 30) / 64'(ENT);
    assign tab[gi] = (FB+1)'(log2_pt(X0, FB));
  end

  logic [VW-1:0]    v;
  logic [PB-1:0]    p;
  logic [VW-1:0]    frac;
  logic [VW+31:0]   sh;
  logic [31+EW:0]   pos;
  logic [IB-1:0]    idx_q;
  logic [31:0]      rem_q;
  logic [PB-1:0]    p_q;

  always_comb begin
    v = (v_i == '0) ? VW'(1) : v_i;
    p = '0;
    for (int i = 0; i < VW; i++) begin
      if (v[i]) begin
        p = PB'(i);
      end
    end
    frac = v & ~(VW'(1) << p);
    sh = {frac, 32'd0} >> p;
    pos = (32+EW)'(sh[31:0]) * (32+EW)'(ENT);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      idx_q <= pos[31+IB:32];
      rem_q <= pos[31:0];
      p_q <= p;
    end
  end

  logic [FB:0]      base;
  logic [FB:0]      nxt;
  logic [FB:0]      diff;
  logic [FB+32:0]   prod;
  logic [L2W-1:0]   l2_d;
  logic [L2W-1:0]   l2_q;

  always_comb begin
    base = tab[TB'(idx_q)];
    nxt = tab[TB'(idx_q) + TB'(1)];
    diff = nxt - base;
    prod = (FB+33)'(diff) * (FB+33)'(rem_q);
    l2_d = L2W'(base) + L2W'(prod >> 32) + (L2W'(p_q) << FB);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      l2_q <= l2_d;
    end
  end

  logic [L2W+31:0] mlg;

  assign mlg = (L2W+32)'(l2_q) * (L2W+32)'(LOG10_2_Q32) + ((L2W+32)'(1) << 31);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      lg_o <= (FB+4)'(mlg >> 32);
    end
  end

endmodule

FILE: sv/hplf_checker.sv
// port level checks for the hata path loss unit
module hplf_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               valid_i,
  input logic               stall_o,
  input logic [11:0]        frequency_mhz_i,
  input logic [16:0]        distance_m_i,
  input logic [13:0]        base_height_dm_i,
  input logic [9:0]         mobile_height_dm_i,
  input logic               urban_i,
  input logic               valid_o,
  input logic               stall_i,
  input logic signed [16:0] path_loss_o,
  input logic               saturated_o
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && stall_i |=> valid_o && $stable(path_loss_o) && $stable(saturated_o))
    else $error("stalled output transaction changed");

  a_sat_val: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && saturated_o |-> (path_loss_o == 17'sd65535) || (path_loss_o == -17'sd16384))
    else $error("saturated result not at a limit");

  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> path_loss_o >= -17'sd16384)
    else $error("result below lower limit");

  a_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stall_o |-> valid_o && stall_i)
    else $error("input stalled without a blocked output");

endmodule

bind hata_path_loss_fixed_unit hplf_checker u_hplf_checker (.*);

FILE: tb/hata_path_loss_fixed_unit_test.sv
// testbench for the hata path loss unit: directed table plus random links, self-checking
`timescale 1ns / 1ps

module hata_path_loss_fixed_unit_test;
  import hplf_pkg::*;

  typedef struct {
    logic signed [16:0] loss;
    logic               sat;
  } loss_result_t;

  typedef struct {
    logic [11:0]        f;
    logic [16:0]        d;
    logic [13:0]        hb;
    logic [9:0]         hm;
    logic               urban;
    logic               typed;
    logic signed [16:0] loss;
    logic               sat;
  } link_row_t;

  localparam int NUM_RANDOM = 1100;
  localparam int NUM_ROWS = 17;

  logic               clk_i;
  logic               rst_ni;
  logic               valid_i;
  logic               stall_o;
  logic [11:0]        frequency_mhz_i;
  logic [16:0]        distance_m_i;
  logic [13:0]        base_height_dm_i;
  logic [9:0]         mobile_height_dm_i;
  logic               urban_i;
  logic               valid_o;
  logic               stall_i;
  logic signed [16:0] path_loss_o;
  logic               saturated_o;

  longint unsigned log2_tab [0:256];
  loss_result_t    pending_losses [$];
  int              mismatches;
  logic            quiet;
  logic            typed_now;
  loss_result_t    typed_loss;

  link_row_t rows [NUM_ROWS] = '{
    '{12'd0, 17'd0, 14'd0, 10'd0, 1'b0, 1'b0, 17'sd0, 1'b0},
    '{12'd1, 17'd1, 14'd1, 10'd1, 1'b0, 1'b0, 17'sd0, 1'b0},
    '{12'd4095, 17'd131071, 14'd16383, 10'd1023, 1'b1, 1'b0, 17'sd0, 1'b0},
    '{12'd4095, 17'd131071, 14'd1, 10'd1, 1'b1, 1'b0, 17'sd0, 1'b0},
    '{12'd1, 17'd131071, 14'd1, 10'd1023, 1'b1, 1'b0, 17'sd0, 1'b0},
    '{12'd1, 17'd1, 14'd16383, 10'd1, 1'b0, 1'b1, -17'sd16384, 1'b1},
    '{12'd1, 17'd1, 14'd10000, 10'd1, 1'b0, 1'b1, -17'sd16384, 1'b1},
    '{12'd100, 17'd5000, 14'd300, 10'd15, 1'b0, 1'b0, 17'sd0, 1'b0},
    '{12'd150, 17'd5000, 14'd300, 10'd15, 1'b0, 1'b0, 17'sd0, 1'b0},
    '{12'd151, 17'd5000, 14'd300, 10'd15, 1'b1, 1'b0, 17'sd0, 1'b0},
    '{12'd200, 17'd5000, 14'd300, 10'd15, 1'b0, 1'b0, 17'sd0, 1'b0},
    '{12'd201, 17'd5000, 14'd300, 10'd15, 1'b1, 1'b0, 17'sd0, 1'b0},
    '{12'd900, 17'd1000, 14'd500, 10'd1000, 1'b0, 1'b0, 17'sd0, 1'b0},
    '{12'd1800, 17'd100000, 14'd10000, 10'd20, 1'b1, 1'b0, 17'sd0, 1'b0},
    '{12'd2000, 17'd20000, 14'd8191, 10'd512, 1'b0, 1'b0, 17'sd0, 1'b0},
    '{12'd2048, 17'd65536, 14'd8192, 10'd511, 1'b1, 1'b0, 17'sd0, 1'b0},
    '{12'd0, 17'd100000, 14'd0, 10'd0, 1'b1, 1'b0, 17'sd0, 1'b0}
  };

  hata_path_loss_fixed_unit DUT (
    .clk_i, .rst_ni, .valid_i, .stall_o, .frequency_mhz_i, .distance_m_i,
    .base_height_dm_i, .mobile_height_dm_i, .urban_i, .valid_o, .stall_i,
    .path_loss_o, .saturated_o
  );

  function automatic longint round_shift(longint x, int s);
    longint half;
    if (s <= 0) return x;
    half = longint'(1) <<< (s - 1);
    if (x >= 0) return (x + half) >>> s;
    return -((-x + half) >>> s);
  endfunction

  function automatic longint round_div(longint x, longint d);
    if (x >= 0) return (x + d / 2) / d;
    return -((-x + d / 2) / d);
  endfunction

  function automatic void fill_log2_tab();
    longint unsigned x;
    longint unsigned r;
    for (int i = 0; i <= 256; i++) begin
      x = ((64'd256 + i) << 30) / 64'd256;
      r = 0;
      for (int k = 0; k < 17; k++) begin
        x = (x * x) >> 30;
        r = r << 1;
        if (x >= 64'h8000_0000) begin
          x = x >> 1;
          r = r | 64'd1;
        end
      end
      log2_tab[i] = (r + 64'd1) >> 1;
    end
  endfunction

  function automatic longint log10_q16(longint unsigned v);
    int              p;
    longint unsigned frac, scaled, pos, idx, rem, base, l2;
    v = v & 64'hFFFF_FFFF;
    if (v == 0) v = 1;
    p = 0;
    while (p < 31 && (v >> (p + 1)) != 0) p++;
    frac = v - (64'd1 << p);
    scaled = (frac << 32) >> p;
    pos = scaled * 64'd256;
    idx = pos >> 32;
    if (idx >= 256) idx = 255;
    rem = pos & 64'hFFFF_FFFF;
    base = log2_tab[idx];
    l2 = base + (((log2_tab[idx + 1] - base) * rem) >> 32);
    l2 = l2 + (longint'(p) << 16);
    return longint'((l2 * longint'(LOG10_2_Q32) + (64'd1 << 31)) >> 32);
  endfunction

  function automatic loss_result_t hata_loss(logic [11:0] f, logic [16:0] d, logic [13:0] hb,
                                             logic [9:0] hm, logic urban);
    longint       one, lf, ld, lhb, t, a, loss, hmv;
    loss_result_t res;
    one = longint'(1) << 16;
    hmv = (hm == 0) ? 1 : longint'(hm);
    lf = log10_q16(f);
    ld = log10_q16(d) - 3 * one;
    lhb = log10_q16(hb) - one;
    if (f > 150 && f <= 200) begin
      t = log10_q16(154 * hmv) - 3 * one;
      a = round_shift(longint'(C_8_29) * round_shift(t * t, 16), 16) - longint'(C_1_1);
    end else if (f > 200) begin
      t = log10_q16(1175 * hmv) - 3 * one;
      a = round_shift(longint'(C_3_2) * round_shift(t * t, 16), 16) - longint'(C_4_97);
    end else begin
      t = round_shift(longint'(C_1_1) * lf, 16) - longint'(C_0_7);
      a = longint'(C_0_8) + round_div(t * hmv, 10) - round_shift(longint'(C_1_56) * lf, 16);
    end
    loss = longint'(C_46_3) + round_shift(longint'(C_33_9) * lf, 16)
         - round_shift(longint'(C_13_82) * lhb, 16) - a
         + round_shift((longint'(C_44_9) - round_shift(longint'(C_6_55) * lhb, 16)) * ld, 16);
    if (urban) loss = loss + longint'(C_3);
    loss = round_shift(loss, 8);
    res.sat = 1'b0;
    if (loss > 65535) begin
      loss = 65535;
      res.sat = 1'b1;
    end else if (loss < -16384) begin
      loss = -16384;
      res.sat = 1'b1;
    end
    res.loss = loss[16:0];
    return res;
  endfunction

  task automatic send_link(link_row_t row);
    if (!quiet && $urandom_range(99) < 5) begin
      valid_i = 1'b0;
      repeat ($urandom_range(3, 1)) @(negedge clk_i);
    end
    frequency_mhz_i = row.f;
    distance_m_i = row.d;
    base_height_dm_i = row.hb;
    mobile_height_dm_i = row.hm;
    urban_i = row.urban;
    typed_now = row.typed;
    typed_loss.loss = row.loss;
    typed_loss.sat = row.sat;
    valid_i = 1'b1;
    do @(posedge clk_i); while (stall_o);
    @(negedge clk_i);
  endtask

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  always @(negedge clk_i) begin
    stall_i <= (!quiet && $urandom_range(99) < 9);
  end

  always @(posedge clk_i) begin
    loss_result_t exp_res;
    if (rst_ni && valid_i && !stall_o) begin
      pending_losses.push_back(typed_now ? typed_loss :
        hata_loss(frequency_mhz_i, distance_m_i, base_height_dm_i, mobile_height_dm_i, urban_i));
    end
    if (rst_ni && valid_o && !stall_i) begin
      if (pending_losses.size() == 0) begin
        $display("%0t: unexpected transaction loss=%0d sat=%0b", $time, path_loss_o, saturated_o);
        mismatches++;
      end else begin
        exp_res = pending_losses.pop_front();
        if (path_loss_o !== exp_res.loss) begin
          $display("%0t: path_loss expected %0d actual %0d", $time, exp_res.loss, path_loss_o);
          mismatches++;
        end
        if (saturated_o !== exp_res.sat) begin
          $display("%0t: saturated expected %0b actual %0b", $time, exp_res.sat, saturated_o);
          mismatches++;
        end
      end
    end
  end

  initial begin
    link_row_t row;
    fill_log2_tab();
    mismatches = 0;
    quiet = 1'b0;
    typed_now = 1'b0;
    typed_loss = '{17'sd0, 1'b0};
    rst_ni = 1'b0;
    valid_i = 1'b0;
    stall_i = 1'b0;
    frequency_mhz_i = '0;
    distance_m_i = '0;
    base_height_dm_i = '0;
    mobile_height_dm_i = '0;
    urban_i = 1'b0;
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    for (int i = 0; i < NUM_ROWS; i++) send_link(rows[i]);
    for (int i = 0; i < NUM_RANDOM; i++) begin
      quiet = (i >= 400 && i < 600);
      row.f = 12'($urandom_range(4095));
      row.d = 17'(($urandom_range(3) == 0) ? $urandom_range(131071)
                                           : $urandom_range(100000, 1));
      row.hb = 14'(($urandom_range(3) == 0) ? $urandom_range(16383)
                                            : $urandom_range(10000, 1));
      row.hm = 10'(($urandom_range(3) == 0) ? $urandom_range(1023)
                                            : $urandom_range(1000, 1));
      row.urban = 1'($urandom_range(1));
      row.typed = 1'b0;
      row.loss = 17'sd0;
      row.sat = 1'b0;
      send_link(row);
    end
    valid_i = 1'b0;
    quiet = 1'b0;
    while (pending_losses.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

FILE: hata_path_loss_fixed_unit.f
sv/hplf_pkg.sv
sv/hplf_log10.sv
sv/hata_path_loss_fixed_unit.sv
sv/hplf_checker.sv
tb/hata_path_loss_fixed_unit_test.sv
